FILE: sv/bbct_pkg.sv
// Shared types and constants for the block buffer cache table.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps

package bbct_pkg;

    localparam int CMD_W    = 2;
    localparam int DEV_W    = 8;
    localparam int BLK_W    = 32;
    localparam int SLOT_W   = 5;
    localparam int CNT_W    = 8;
    localparam int STATUS_W = 2;

    localparam logic [CMD_W-1:0] CMD_ACQUIRE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DROP    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_ADD     = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOFREE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_UNDER  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_OVER   = 2'd3;

    localparam logic [CNT_W-1:0] COUNT_MAX = 8'd255;

    // One slot of the tag table as it sits in the entry memory.
    typedef struct packed {
        logic [DEV_W-1:0] dev;
        logic [BLK_W-1:0] blk;
        logic [CNT_W-1:0] cnt;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // Which source feeds the entry memory read port.
    typedef enum logic [1:0] {
        PH_BUCKET,
        PH_SCAN,
        PH_SLOT
    } phase_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_BKT_SCAN,
        S_ENT_SCAN,
        S_SLOT_RD,
        S_SLOT_WAIT,
        S_FINISH
    } state_t;

    // Controller to datapath.
    typedef struct packed {
        logic   capture;
        phase_t phase;
        logic   issue;
        logic   finish;
    } dp_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic is_acquire;
        logic slot_op;
        logic found;
        logic bkt_end;
        logic ent_end;
        logic pipe_busy;
    } dp_stat_t;

endpackage

FILE: sv/bbct_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// Stand-alone; no package dependencies.
`timescale 1ns / 1ps

module bbct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: sv/bbct_ctrl.sv
// Sequencer for the block buffer cache table: handshakes and scan phases.
// Depends on bbct_pkg for the state, command and status types.
`timescale 1ns / 1ps

module bbct_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    input  bbct_pkg::dp_stat_t dp_stat,
    output bbct_pkg::dp_cmd_t  dp_cmd
);

    bbct_pkg::state_t state_reg;
    bbct_pkg::state_t state_next;
    logic             out_valid_reg;
    logic             out_free;

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != bbct_pkg::S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        dp_cmd.capture = 1'b0;
        dp_cmd.phase   = bbct_pkg::PH_SLOT;
        dp_cmd.issue   = 1'b0;
        dp_cmd.finish  = 1'b0;
        case (state_reg)
            bbct_pkg::S_IDLE:
            begin
                dp_cmd.capture = in_valid;
            end
            bbct_pkg::S_BKT_SCAN:
            begin
                dp_cmd.phase = bbct_pkg::PH_BUCKET;
                dp_cmd.issue = !dp_stat.found && !dp_stat.bkt_end;
            end
            bbct_pkg::S_ENT_SCAN:
            begin
                dp_cmd.phase = bbct_pkg::PH_SCAN;
                dp_cmd.issue = !dp_stat.found && !dp_stat.ent_end;
            end
            bbct_pkg::S_SLOT_RD:
            begin
                dp_cmd.issue = 1'b1;
            end
            bbct_pkg::S_FINISH:
            begin
                dp_cmd.finish = out_free;
            end
            default:
            begin
                dp_cmd.capture = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bbct_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = bbct_pkg::S_DISPATCH;
                end
            end
            bbct_pkg::S_DISPATCH:
            begin
                if (dp_stat.is_acquire)
                begin
                    state_next = bbct_pkg::S_BKT_SCAN;
                end
                else if (dp_stat.slot_op)
                begin
                    state_next = bbct_pkg::S_SLOT_RD;
                end
                else
                begin
                    state_next = bbct_pkg::S_FINISH;
                end
            end
            bbct_pkg::S_BKT_SCAN:
            begin
                if (dp_stat.found || dp_stat.bkt_end)
                begin
                    if (!dp_stat.pipe_busy)
                    begin
                        state_next = dp_stat.found ? bbct_pkg::S_FINISH : bbct_pkg::S_ENT_SCAN;
                    end
                end
            end
            bbct_pkg::S_ENT_SCAN:
            begin
                if ((dp_stat.found || dp_stat.ent_end) && !dp_stat.pipe_busy)
                begin
                    state_next = bbct_pkg::S_FINISH;
                end
            end
            bbct_pkg::S_SLOT_RD:
            begin
                state_next = bbct_pkg::S_SLOT_WAIT;
            end
            bbct_pkg::S_SLOT_WAIT:
            begin
                state_next = bbct_pkg::S_FINISH;
            end
            bbct_pkg::S_FINISH:
            begin
                if (out_free)
                begin
                    state_next = bbct_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = bbct_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bbct_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (dp_cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

FILE: sv/bbct_dp.sv
// Datapath of the block buffer cache table: entry and bucket memories, scan pipeline,
// selection registers, update logic and the result register.
// Depends on bbct_pkg and bbct_ram.
`timescale 1ns / 1ps

module bbct_dp #(
    parameter int ENTRIES = 32,
    parameter int BUCKETS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [bbct_pkg::CMD_W-1:0]    command,
    input  logic [bbct_pkg::DEV_W-1:0]    device,
    input  logic [bbct_pkg::BLK_W-1:0]    block_number,
    input  logic [bbct_pkg::SLOT_W-1:0]   slot,
    output logic [bbct_pkg::SLOT_W-1:0]   slot_out,
    output logic                          hit,
    output logic                          needs_read,
    output logic [bbct_pkg::STATUS_W-1:0] status,
    input  bbct_pkg::dp_cmd_t             dp_cmd,
    output bbct_pkg::dp_stat_t            dp_stat
);

    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int BKT_W   = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int PTR_MAX = (ENTRIES > BUCKETS) ? ENTRIES : BUCKETS;
    localparam int PTR_W   = $clog2(PTR_MAX);

    // Captured request.
    logic [bbct_pkg::CMD_W-1:0]  cmd_reg;
    logic [bbct_pkg::DEV_W-1:0]  dev_reg;
    logic [bbct_pkg::BLK_W-1:0]  blk_reg;
    logic [bbct_pkg::SLOT_W-1:0] slot_reg;
    logic                        slot_ok;

    // Scan counters.
    logic [BKT_W:0]   bcnt_reg;
    logic [IDX_W:0]   ecnt_reg;
    logic [BKT_W-1:0] ebkt_reg;

    // Per-entry and per-bucket flags; an entry or bucket never written reads as its reset value.
    logic [ENTRIES-1:0] entry_init_reg;
    logic [ENTRIES-1:0] data_valid_reg;
    logic [BUCKETS-1:0] bucket_init_reg;

    // Bucket read stage.
    logic             bk_valid_reg;
    logic             bk_init_reg;
    logic [BKT_W-1:0] bk_idx_reg;
    logic [PTR_W-1:0] bkt_rdata;
    logic [PTR_W-1:0] ptr_eff;
    logic             ptr_ok;

    // Entry read stage.
    logic                         rd_en;
    logic [IDX_W-1:0]             rd_addr;
    logic [BKT_W-1:0]             rd_bkt;
    logic                         rd_valid_reg;
    logic                         rd_init_reg;
    logic [IDX_W-1:0]             rd_idx_reg;
    logic [BKT_W-1:0]             rd_bkt_reg;
    logic [bbct_pkg::ENTRY_W-1:0] ent_rdata;
    bbct_pkg::entry_t             rd_entry;
    logic                         tag_hit;
    logic                         take_match;
    logic                         take_free;
    logic                         take_slot;

    // Selection registers.
    logic             found_reg;
    logic             free_found_reg;
    logic             sel_upd_reg;
    logic [IDX_W-1:0] sel_idx_reg;
    logic [BKT_W-1:0] sel_bkt_reg;
    logic [IDX_W-1:0] free_idx_reg;
    bbct_pkg::entry_t sel_entry_reg;

    // Update and result.
    logic                          wr_en;
    logic [IDX_W-1:0]              wr_idx;
    bbct_pkg::entry_t              wr_entry;
    logic                          bkt_we;
    logic [bbct_pkg::SLOT_W-1:0]   res_slot;
    logic                          res_hit;
    logic                          res_nread;
    logic [bbct_pkg::STATUS_W-1:0] res_status;
    logic [bbct_pkg::SLOT_W-1:0]   slot_out_reg;
    logic                          hit_reg;
    logic                          needs_read_reg;
    logic [bbct_pkg::STATUS_W-1:0] status_reg;

    assign slot_ok = ({27'd0, slot_reg} < 32'(ENTRIES));

    assign dp_stat.is_acquire = (cmd_reg == bbct_pkg::CMD_ACQUIRE);
    assign dp_stat.slot_op    = ((cmd_reg == bbct_pkg::CMD_DROP) ||
                                 (cmd_reg == bbct_pkg::CMD_ADD)) && slot_ok;
    assign dp_stat.found      = found_reg;
    assign dp_stat.bkt_end    = (bcnt_reg == (BKT_W + 1)'(BUCKETS));
    assign dp_stat.ent_end    = (ecnt_reg == (IDX_W + 1)'(ENTRIES));
    assign dp_stat.pipe_busy  = bk_valid_reg || rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (dp_cmd.capture)
        begin
            cmd_reg  <= command;
            dev_reg  <= device;
            blk_reg  <= block_number;
            slot_reg <= slot;
        end
    end

    // Bucket memory: probed in order during the first phase, written on a scan hit.
    bbct_ram #(
        .WIDTH(PTR_W),
        .DEPTH(BUCKETS)
    ) u_bucket_ram (
        .clk  (clk),
        .we   (bkt_we && dp_cmd.finish),
        .waddr(sel_bkt_reg),
        .wdata(PTR_W'(sel_idx_reg)),
        .raddr(bcnt_reg[BKT_W-1:0]),
        .rdata(bkt_rdata)
    );

    assign ptr_eff = bk_init_reg ? bkt_rdata : PTR_W'(bk_idx_reg);
    assign ptr_ok  = ({1'b0, ptr_eff} < (PTR_W + 1)'(ENTRIES));

    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = IDX_W'(slot_reg);
        rd_bkt  = ebkt_reg;
        case (dp_cmd.phase)
            bbct_pkg::PH_BUCKET:
            begin
                rd_en   = bk_valid_reg && ptr_ok;
                rd_addr = IDX_W'(ptr_eff);
            end
            bbct_pkg::PH_SCAN:
            begin
                rd_en   = dp_cmd.issue;
                rd_addr = ecnt_reg[IDX_W-1:0];
            end
            bbct_pkg::PH_SLOT:
            begin
                rd_en = dp_cmd.issue;
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    // Entry memory: tag and reference count of every slot.
    bbct_ram #(
        .WIDTH(bbct_pkg::ENTRY_W),
        .DEPTH(ENTRIES)
    ) u_entry_ram (
        .clk  (clk),
        .we   (wr_en && dp_cmd.finish),
        .waddr(wr_idx),
        .wdata(wr_entry),
        .raddr(rd_addr),
        .rdata(ent_rdata)
    );

    assign rd_entry = rd_init_reg ? bbct_pkg::entry_t'(ent_rdata) : '0;
    assign tag_hit  = (rd_entry.dev == dev_reg) && (rd_entry.blk == blk_reg);

    assign take_match = rd_valid_reg && !found_reg && tag_hit &&
                        ((dp_cmd.phase == bbct_pkg::PH_BUCKET) ||
                         (dp_cmd.phase == bbct_pkg::PH_SCAN));
    assign take_free  = rd_valid_reg && !free_found_reg && (rd_entry.cnt == '0) &&
                        (dp_cmd.phase == bbct_pkg::PH_SCAN);
    assign take_slot  = rd_valid_reg && (dp_cmd.phase == bbct_pkg::PH_SLOT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bcnt_reg       <= '0;
            ecnt_reg       <= '0;
            ebkt_reg       <= '0;
            bk_valid_reg   <= 1'b0;
            rd_valid_reg   <= 1'b0;
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
            sel_upd_reg    <= 1'b0;
        end
        else
        begin
            bk_valid_reg <= dp_cmd.issue && (dp_cmd.phase == bbct_pkg::PH_BUCKET);
            rd_valid_reg <= rd_en;
            if (dp_cmd.capture)
            begin
                bcnt_reg       <= '0;
                ecnt_reg       <= '0;
                ebkt_reg       <= '0;
                found_reg      <= 1'b0;
                free_found_reg <= 1'b0;
                sel_upd_reg    <= 1'b0;
            end
            else
            begin
                if (dp_cmd.issue && (dp_cmd.phase == bbct_pkg::PH_BUCKET))
                begin
                    bcnt_reg <= bcnt_reg + 1'b1;
                end
                if (dp_cmd.issue && (dp_cmd.phase == bbct_pkg::PH_SCAN))
                begin
                    ecnt_reg <= ecnt_reg + 1'b1;
                    if (ebkt_reg == BKT_W'(BUCKETS - 1))
                    begin
                        ebkt_reg <= '0;
                    end
                    else
                    begin
                        ebkt_reg <= ebkt_reg + 1'b1;
                    end
                end
                if (take_match)
                begin
                    found_reg   <= 1'b1;
                    sel_upd_reg <= (dp_cmd.phase == bbct_pkg::PH_SCAN);
                end
                if (take_free)
                begin
                    free_found_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        bk_init_reg <= bucket_init_reg[bcnt_reg[BKT_W-1:0]];
        bk_idx_reg  <= bcnt_reg[BKT_W-1:0];
        rd_init_reg <= entry_init_reg[rd_addr];
        rd_idx_reg  <= rd_addr;
        rd_bkt_reg  <= rd_bkt;
        if (take_match || take_slot)
        begin
            sel_idx_reg   <= rd_idx_reg;
            sel_bkt_reg   <= rd_bkt_reg;
            sel_entry_reg <= rd_entry;
        end
        if (take_free)
        begin
            free_idx_reg <= rd_idx_reg;
        end
    end

    // Update of the chosen slot and the result of the transaction.
    always_comb
    begin
        wr_en        = 1'b0;
        wr_idx       = sel_idx_reg;
        wr_entry.dev = dev_reg;
        wr_entry.blk = blk_reg;
        wr_entry.cnt = sel_entry_reg.cnt + 1'b1;
        bkt_we       = 1'b0;
        res_slot     = '0;
        res_hit      = 1'b0;
        res_nread    = 1'b0;
        res_status   = bbct_pkg::ST_OK;
        case (cmd_reg)
            bbct_pkg::CMD_ACQUIRE:
            begin
                if (found_reg)
                begin
                    res_slot = bbct_pkg::SLOT_W'(sel_idx_reg);
                    res_hit  = 1'b1;
                    if (sel_entry_reg.cnt == bbct_pkg::COUNT_MAX)
                    begin
                        res_status = bbct_pkg::ST_OVER;
                    end
                    else
                    begin
                        wr_en     = 1'b1;
                        bkt_we    = sel_upd_reg;
                        res_nread = !data_valid_reg[sel_idx_reg];
                    end
                end
                else if (free_found_reg)
                begin
                    wr_en        = 1'b1;
                    wr_idx       = free_idx_reg;
                    wr_entry.cnt = bbct_pkg::CNT_W'(1);
                    res_slot     = bbct_pkg::SLOT_W'(free_idx_reg);
                    res_nread    = 1'b1;
                end
                else
                begin
                    res_status = bbct_pkg::ST_NOFREE;
                end
            end
            bbct_pkg::CMD_DROP:
            begin
                res_slot     = slot_reg;
                wr_entry.dev = sel_entry_reg.dev;
                wr_entry.blk = sel_entry_reg.blk;
                wr_entry.cnt = sel_entry_reg.cnt - 1'b1;
                if (slot_ok)
                begin
                    if (sel_entry_reg.cnt == '0)
                    begin
                        res_status = bbct_pkg::ST_UNDER;
                    end
                    else
                    begin
                        wr_en = 1'b1;
                    end
                end
            end
            bbct_pkg::CMD_ADD:
            begin
                res_slot     = slot_reg;
                wr_entry.dev = sel_entry_reg.dev;
                wr_entry.blk = sel_entry_reg.blk;
                if (slot_ok)
                begin
                    if (sel_entry_reg.cnt == bbct_pkg::COUNT_MAX)
                    begin
                        res_status = bbct_pkg::ST_OVER;
                    end
                    else
                    begin
                        wr_en = 1'b1;
                    end
                end
            end
            default:
            begin
                res_slot = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_init_reg  <= '0;
            data_valid_reg  <= '0;
            bucket_init_reg <= '0;
        end
        else if (dp_cmd.finish)
        begin
            if (wr_en)
            begin
                entry_init_reg[wr_idx] <= 1'b1;
                if (cmd_reg == bbct_pkg::CMD_ACQUIRE)
                begin
                    data_valid_reg[wr_idx] <= 1'b1;
                end
            end
            if (bkt_we)
            begin
                bucket_init_reg[sel_bkt_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (dp_cmd.finish)
        begin
            slot_out_reg   <= res_slot;
            hit_reg        <= res_hit;
            needs_read_reg <= res_nread;
            status_reg     <= res_status;
        end
    end

    assign slot_out   = slot_out_reg;
    assign hit        = hit_reg;
    assign needs_read = needs_read_reg;
    assign status     = status_reg;

endmodule

FILE: sv/block_buffer_cache_table.sv
// Top level of the block buffer cache table: tag table of buffer slots with reference counts.
// Depends on bbct_pkg, bbct_ctrl, bbct_dp and (through bbct_dp) bbct_ram.
`timescale 1ns / 1ps

// The block keeps ENTRIES buffer slots, each tagged with a device and a block number and
// carrying a data-valid bit and an 8-bit reference count, plus BUCKETS bucket pointers that
// each name one slot. An acquire (command 0) first probes the slot named by each bucket,
// bucket 0 first, then scans every slot from the lowest; a hit in that scan repoints bucket
// (slot mod BUCKETS) at the slot. On a miss the lowest slot with a zero count is taken, retagged
// and given a count of one. The result reports the slot, whether it hit, whether the data must
// be read from disk, and a status: 0 ok, 1 no free slot, 2 count underflow, 3 count overflow.
// Commands 1 and 2 drop and add one reference on the given slot; an error changes nothing.
// Both channels use valid and stall, and each transaction yields exactly one result. Items are
// handled one at a time. An acquire runs the bucket probes, pipelined through the bucket memory
// and then the entry memory at one bucket per cycle, followed by the slot scan at one entry per
// cycle through the single read port of the entry memory; a hit in a bucket skips the scan.
// Reset takes effect at once; slots and buckets never written read as their reset contents,
// so there is no clearing pass. A finished result waits in the output register until taken,
// and the next transaction is accepted while it waits.

module block_buffer_cache_table #(
    parameter int ENTRIES = 32,
    parameter int BUCKETS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [bbct_pkg::CMD_W-1:0]    command,
    input  logic [bbct_pkg::DEV_W-1:0]    device,
    input  logic [bbct_pkg::BLK_W-1:0]    block_number,
    input  logic [bbct_pkg::SLOT_W-1:0]   slot,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [bbct_pkg::SLOT_W-1:0]   slot_out,
    output logic                          hit,
    output logic                          needs_read,
    output logic [bbct_pkg::STATUS_W-1:0] status
);

    // Command and status between the sequencer and the datapath.
    bbct_pkg::dp_cmd_t  dp_cmd;
    bbct_pkg::dp_stat_t dp_stat;

    // The sequencer owns both handshakes and steps through the bucket probe, the slot scan,
    // the single-slot read for drop and add, and the final update.
    bbct_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .dp_stat  (dp_stat),
        .dp_cmd   (dp_cmd)
    );

    // The datapath holds the tables, the scan pipeline and the result register.
    bbct_dp #(
        .ENTRIES(ENTRIES),
        .BUCKETS(BUCKETS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .command     (command),
        .device      (device),
        .block_number(block_number),
        .slot        (slot),
        .slot_out    (slot_out),
        .hit         (hit),
        .needs_read  (needs_read),
        .status      (status),
        .dp_cmd      (dp_cmd),
        .dp_stat     (dp_stat)
    );

endmodule

FILE: dv/block_buffer_cache_table_tb.sv
// Self-checking testbench for block_buffer_cache_table: slot tag table with reference counts.
// Depends on bbct_pkg and the block_buffer_cache_table RTL; needs no other file.
`timescale 1ns / 1ps

module block_buffer_cache_table_tb;

    localparam int ENTRIES    = 32;
    localparam int BUCKETS    = 16;
    localparam int TAG_POOL   = 40;
    localparam int HOLD_LEN   = 300;
    localparam int TIMEOUT_NS = 10_000_000;

    // Command code 3 is not used by the block; it must come back as an all-zero result.
    localparam logic [bbct_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

    // One result transaction as the block reports it.
    typedef struct packed {
        logic [bbct_pkg::SLOT_W-1:0]   slot;
        logic                          hit;
        logic                          needs_read;
        logic [bbct_pkg::STATUS_W-1:0] status;
    } grant_t;

    logic                          clk;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_stall;
    logic [bbct_pkg::CMD_W-1:0]    command;
    logic [bbct_pkg::DEV_W-1:0]    device;
    logic [bbct_pkg::BLK_W-1:0]    block_number;
    logic [bbct_pkg::SLOT_W-1:0]   slot;
    logic                          out_valid;
    logic                          out_stall;
    logic [bbct_pkg::SLOT_W-1:0]   slot_out;
    logic                          hit;
    logic                          needs_read;
    logic [bbct_pkg::STATUS_W-1:0] status;

    // Shadow copy of the table, updated whenever a request is accepted.
    logic [bbct_pkg::DEV_W-1:0] tag_dev[ENTRIES];
    logic [bbct_pkg::BLK_W-1:0] tag_blk[ENTRIES];
    logic                       data_ok[ENTRIES];
    logic [bbct_pkg::CNT_W-1:0] ref_cnt[ENTRIES];
    int                         bucket_slot[BUCKETS];

    // Results still owed by the block, oldest first.
    grant_t pending_grants[$];

    // Tags that the random traffic keeps coming back to, so that hits are common.
    logic [bbct_pkg::DEV_W-1:0] pool_dev[TAG_POOL];
    logic [bbct_pkg::BLK_W-1:0] pool_blk[TAG_POOL];

    int mismatch_count;
    bit sender_gaps;
    bit receiver_gaps;
    int hold_requests;

    block_buffer_cache_table #(
        .ENTRIES(ENTRIES),
        .BUCKETS(BUCKETS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .command(command),
        .device(device),
        .block_number(block_number),
        .slot(slot),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .slot_out(slot_out),
        .hit(hit),
        .needs_read(needs_read),
        .status(status)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // The run should finish well inside this; if it does not, something hung.
    initial
    begin
        #(TIMEOUT_NS);
        $display("FAIL block_buffer_cache_table");
        $finish;
    end

    // Applies one command to the shadow table and returns the result the block owes.
    // An acquire probes the bucket-named slots first, then scans all slots; only a hit
    // found by the scan repoints a bucket. A hit on a saturated count changes nothing.
    function automatic grant_t table_apply(input logic [bbct_pkg::CMD_W-1:0] cmd,
                                           input logic [bbct_pkg::DEV_W-1:0] dev,
                                           input logic [bbct_pkg::BLK_W-1:0] blk,
                                           input logic [bbct_pkg::SLOT_W-1:0] slt);
        grant_t g;
        int     found;
        bit     by_scan;
        g = '0;
        found = -1;
        by_scan = 1'b0;
        if (cmd == bbct_pkg::CMD_ACQUIRE)
        begin
            for (int b = 0; b < BUCKETS && found < 0; b++)
            begin
                if (bucket_slot[b] < ENTRIES && tag_dev[bucket_slot[b]] == dev
                        && tag_blk[bucket_slot[b]] == blk)
                    found = bucket_slot[b];
            end
            for (int e = 0; e < ENTRIES && found < 0; e++)
            begin
                if (tag_dev[e] == dev && tag_blk[e] == blk)
                begin
                    found = e;
                    by_scan = 1'b1;
                end
            end
            if (found >= 0)
            begin
                g.slot = bbct_pkg::SLOT_W'(found);
                g.hit = 1'b1;
                if (ref_cnt[found] == bbct_pkg::COUNT_MAX)
                    g.status = bbct_pkg::ST_OVER;
                else
                begin
                    ref_cnt[found] = ref_cnt[found] + 1'b1;
                    if (by_scan)
                        bucket_slot[found % BUCKETS] = found;
                    g.needs_read = !data_ok[found];
                    data_ok[found] = 1'b1;
                    g.status = bbct_pkg::ST_OK;
                end
            end
            else
            begin
                // Miss: take the lowest slot nobody holds a reference to.
                for (int e = 0; e < ENTRIES && found < 0; e++)
                begin
                    if (ref_cnt[e] == '0)
                        found = e;
                end
                if (found >= 0)
                begin
                    tag_dev[found] = dev;
                    tag_blk[found] = blk;
                    ref_cnt[found] = bbct_pkg::CNT_W'(1);
                    data_ok[found] = 1'b1;
                    g.slot = bbct_pkg::SLOT_W'(found);
                    g.needs_read = 1'b1;
                    g.status = bbct_pkg::ST_OK;
                end
                else
                    g.status = bbct_pkg::ST_NOFREE;
            end
        end
        else if (cmd == bbct_pkg::CMD_DROP || cmd == bbct_pkg::CMD_ADD)
        begin
            g.slot = slt;
            g.status = bbct_pkg::ST_OK;
            if (slt < ENTRIES)
            begin
                if (cmd == bbct_pkg::CMD_DROP)
                begin
                    if (ref_cnt[slt] == '0)
                        g.status = bbct_pkg::ST_UNDER;
                    else
                        ref_cnt[slt] = ref_cnt[slt] - 1'b1;
                end
                else
                begin
                    if (ref_cnt[slt] == bbct_pkg::COUNT_MAX)
                        g.status = bbct_pkg::ST_OVER;
                    else
                        ref_cnt[slt] = ref_cnt[slt] + 1'b1;
                end
            end
        end
        return g;
    endfunction

    // Offers one request, holding it until the block takes it, then records the expected
    // result. Valid is left high on return so that back-to-back requests keep it high;
    // a sender gap or wait_for_results lowers it.
    task automatic issue_request(input logic [bbct_pkg::CMD_W-1:0] cmd,
                                 input logic [bbct_pkg::DEV_W-1:0] dev,
                                 input logic [bbct_pkg::BLK_W-1:0] blk,
                                 input logic [bbct_pkg::SLOT_W-1:0] slt);
        int gap;
        if (sender_gaps && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 16);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        command      <= cmd;
        device       <= dev;
        block_number <= blk;
        slot         <= slt;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_grants.push_back(table_apply(cmd, dev, blk, slt));
    endtask

    // The sender goes quiet until every owed result has been taken.
    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (pending_grants.size() != 0)
            @(posedge clk);
    endtask

    // After reset every slot is tagged device 0 block 0, so that tag hits at once and
    // reports that its data must be read. Also covers underflow, the unused command and
    // the all-ones extremes of the fields.
    task automatic test_reset_tags();
        issue_request(bbct_pkg::CMD_ACQUIRE, 8'h00, 32'h0000_0000, 5'd0);
        issue_request(bbct_pkg::CMD_ACQUIRE, 8'h00, 32'h0000_0000, 5'd31);
        issue_request(bbct_pkg::CMD_DROP, 8'hFF, 32'hFFFF_FFFF, 5'd0);
        issue_request(bbct_pkg::CMD_DROP, 8'h00, 32'h0000_0000, 5'd0);
        issue_request(bbct_pkg::CMD_DROP, 8'h00, 32'h0000_0000, 5'd0);
        issue_request(bbct_pkg::CMD_ADD, 8'h00, 32'h0000_0000, 5'd31);
        issue_request(bbct_pkg::CMD_DROP, 8'h00, 32'h0000_0000, 5'd31);
        issue_request(bbct_pkg::CMD_DROP, 8'h00, 32'h0000_0000, 5'd31);
        issue_request(CMD_UNUSED, 8'hFF, 32'hFFFF_FFFF, 5'd31);
        issue_request(bbct_pkg::CMD_ACQUIRE, 8'hFF, 32'hFFFF_FFFF, 5'd31);
        issue_request(bbct_pkg::CMD_ACQUIRE, 8'h00, 32'h0000_0000, 5'd0);
        issue_request(bbct_pkg::CMD_ACQUIRE, 8'hFF, 32'hFFFF_FFFF, 5'd0);
        issue_request(bbct_pkg::CMD_ACQUIRE, 8'h55, 32'hAAAA_5555, 5'd10);
        issue_request(bbct_pkg::CMD_ACQUIRE, 8'hAA, 32'h5555_AAAA, 5'd21);
        issue_request(bbct_pkg::CMD_ADD, 8'h00, 32'h0000_0000, 5'd2);
        issue_request(bbct_pkg::CMD_DROP, 8'h00, 32'h0000_0000, 5'd2);
        issue_request(CMD_UNUSED, 8'h00, 32'h0000_0000, 5'd0);
        wait_for_results();
    endtask

    // Fills every slot with a held reference, then misses twice to get the no-free-slot
    // status, hits a held tag, and finally drops one reference on every slot.
    task automatic test_table_full();
        bit has_free;
        do
        begin
            has_free = 1'b0;
            foreach (ref_cnt[i])
                if (ref_cnt[i] == '0)
                    has_free = 1'b1;
            if (has_free)
                issue_request(bbct_pkg::CMD_ACQUIRE, bbct_pkg::DEV_W'($urandom_range(0, 255)),
                              $urandom, bbct_pkg::SLOT_W'($urandom_range(0, 31)));
        end
        while (has_free);
        repeat (2)
            issue_request(bbct_pkg::CMD_ACQUIRE, bbct_pkg::DEV_W'($urandom_range(0, 255)),
                          $urandom, bbct_pkg::SLOT_W'($urandom_range(0, 31)));
        issue_request(bbct_pkg::CMD_ACQUIRE, tag_dev[ENTRIES-1], tag_blk[ENTRIES-1], 5'd0);
        for (int e = 0; e < ENTRIES; e++)
            issue_request(bbct_pkg::CMD_DROP, bbct_pkg::DEV_W'($urandom_range(0, 255)),
                          $urandom, bbct_pkg::SLOT_W'(e));
        wait_for_results();
    endtask

    // Drives one slot's count to its ceiling, where both an add and an acquire hit
    // must report overflow and leave the table alone.
    task automatic test_count_saturation();
        logic [bbct_pkg::SLOT_W-1:0] pinned;
        pinned = bbct_pkg::SLOT_W'($urandom_range(0, ENTRIES - 1));
        while (ref_cnt[pinned] != bbct_pkg::COUNT_MAX)
            issue_request(bbct_pkg::CMD_ADD, bbct_pkg::DEV_W'($urandom_range(0, 255)),
                          $urandom, pinned);
        issue_request(bbct_pkg::CMD_ADD, 8'h00, 32'h0000_0000, pinned);
        issue_request(bbct_pkg::CMD_ACQUIRE, tag_dev[pinned], tag_blk[pinned], pinned);
        issue_request(bbct_pkg::CMD_DROP, 8'h00, 32'h0000_0000, pinned);
        issue_request(bbct_pkg::CMD_ADD, 8'h00, 32'h0000_0000, pinned);
        issue_request(bbct_pkg::CMD_ADD, 8'h00, 32'h0000_0000, pinned);
        wait_for_results();
    endtask

    // The receiver holds off for a long stretch while the sender keeps offering
    // requests back to back, so the block's output fills and it stalls its input.
    task automatic test_backpressure();
        sender_gaps = 1'b0;
        hold_requests <= hold_requests + 1;
        for (int n = 0; n < 12; n++)
            issue_request((n % 3 == 1) ? bbct_pkg::CMD_DROP : bbct_pkg::CMD_ACQUIRE,
                          pool_dev[n], pool_blk[n], bbct_pkg::SLOT_W'($urandom_range(0, 31)));
        wait_for_results();
        sender_gaps = 1'b1;
    endtask

    // Mostly meaningful traffic: acquires of recurring tags and drops of slots that
    // are held, with some fresh tags, adds, drops at zero and the unused command mixed in.
    task automatic test_random_traffic(input int count);
        int                          roll;
        int                          start;
        logic [bbct_pkg::SLOT_W-1:0] target;
        for (int n = 0; n < count; n++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 38)
            begin
                start = $urandom_range(0, TAG_POOL - 1);
                if ($urandom_range(0, 6) == 0)
                    issue_request(bbct_pkg::CMD_ACQUIRE,
                                  bbct_pkg::DEV_W'($urandom_range(0, 255)), $urandom,
                                  bbct_pkg::SLOT_W'($urandom_range(0, 31)));
                else
                    issue_request(bbct_pkg::CMD_ACQUIRE, pool_dev[start], pool_blk[start],
                                  bbct_pkg::SLOT_W'($urandom_range(0, 31)));
            end
            else if (roll < 83)
            begin
                // Prefer a slot that holds a reference; otherwise this is an underflow probe.
                target = bbct_pkg::SLOT_W'($urandom_range(0, ENTRIES - 1));
                if ($urandom_range(0, 4) != 0)
                begin
                    start = int'(target);
                    for (int k = 0; k < ENTRIES; k++)
                        if (ref_cnt[(start + k) % ENTRIES] != '0
                                && ref_cnt[target] == '0)
                            target = bbct_pkg::SLOT_W'((start + k) % ENTRIES);
                end
                issue_request(bbct_pkg::CMD_DROP, bbct_pkg::DEV_W'($urandom_range(0, 255)),
                              $urandom, target);
            end
            else if (roll < 93)
                issue_request(bbct_pkg::CMD_ADD, bbct_pkg::DEV_W'($urandom_range(0, 255)),
                              $urandom, bbct_pkg::SLOT_W'($urandom_range(0, 31)));
            else
                issue_request(CMD_UNUSED, bbct_pkg::DEV_W'($urandom_range(0, 255)), $urandom,
                              bbct_pkg::SLOT_W'($urandom_range(0, 31)));
        end
        wait_for_results();
    endtask

    // Receiver: random stall bursts, plus a long hold whenever a test bumps hold_requests.
    // The hold is counted here so the sender is free to keep pushing.
    initial
    begin
        int hold_left;
        int burst_left;
        int holds_seen;
        hold_left = 0;
        burst_left = 0;
        holds_seen = 0;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_requests != holds_seen)
            begin
                holds_seen = hold_requests;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (burst_left > 0)
            begin
                burst_left--;
                out_stall <= 1'b1;
            end
            else if (receiver_gaps && $urandom_range(0, 5) == 0)
            begin
                burst_left = $urandom_range(0, 15);
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    task automatic check_field(input string what, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            mismatch_count++;
            $display("%0t ns: %s mismatch, expected %0d actual %0d", $time, what, want, got);
        end
    endtask

    // Every result the block hands over is matched against the oldest owed result.
    always @(posedge clk)
    begin
        grant_t owed;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_grants.size() == 0)
            begin
                mismatch_count++;
                $display("%0t ns: result with nothing expected, expected none actual %s",
                         $time, "");
                $display("    slot %0d hit %0d needs_read %0d status %0d",
                         slot_out, hit, needs_read, status);
            end
            else
            begin
                owed = pending_grants.pop_front();
                check_field("slot_out", 32'(owed.slot), 32'(slot_out));
                check_field("hit", 32'(owed.hit), 32'(hit));
                check_field("needs_read", 32'(owed.needs_read), 32'(needs_read));
                check_field("status", 32'(owed.status), 32'(status));
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        command = bbct_pkg::CMD_ACQUIRE;
        device = '0;
        block_number = '0;
        slot = '0;
        mismatch_count = 0;
        hold_requests = 0;
        sender_gaps = 1'b1;
        receiver_gaps = 1'b1;
        for (int e = 0; e < ENTRIES; e++)
        begin
            tag_dev[e] = '0;
            tag_blk[e] = '0;
            data_ok[e] = 1'b0;
            ref_cnt[e] = '0;
        end
        for (int b = 0; b < BUCKETS; b++)
            bucket_slot[b] = b;
        for (int p = 0; p < TAG_POOL; p++)
        begin
            pool_dev[p] = bbct_pkg::DEV_W'($urandom_range(0, 255));
            pool_blk[p] = $urandom;
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_tags();
        test_table_full();
        test_count_saturation();
        test_backpressure();
        test_random_traffic(350);

        // The closing stretch runs with neither side idling.
        sender_gaps = 1'b0;
        receiver_gaps = 1'b0;
        test_random_traffic(150);

        // Give a stray extra result time to show up before judging the run.
        repeat (100) @(posedge clk);
        if (mismatch_count == 0)
            $display("PASS block_buffer_cache_table");
        else
            $display("FAIL block_buffer_cache_table");
        $finish;
    end

endmodule
